>>> rtl/core/chte_pkg.sv
// ----------------------------------------------------------------------------
// chte_pkg
// Shared types, constants and the key hash for the chained hash table engine.
// ----------------------------------------------------------------------------
package chte_pkg;

	localparam int MAX_BUCKETS_LOG2 = 10;
	localparam int NODE_POOL        = 1024;
	localparam int NODE_W           = $clog2(NODE_POOL);
	localparam int LINK_W           = NODE_W + 1;
	localparam int BUCKETS          = 1 << MAX_BUCKETS_LOG2;
	localparam int MIN_BUCKETS_LOG2 = 4;

	typedef logic [LINK_W-1:0]           link_t;
	typedef logic [NODE_W-1:0]           node_t;
	typedef logic [MAX_BUCKETS_LOG2-1:0] bkt_t;
	typedef logic [LINK_W-1:0]           cnt_t;

	localparam link_t NULL_LINK = link_t'(NODE_POOL);

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_LOOKUP = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_HASH2,
		S_HASH3,
		S_HEAD,
		S_NODE,
		S_CHECK,
		S_ALLOC,
		S_ALLOC2,
		S_DONE,
		S_FREE
	} state_t;

	// key hash, two of its six steps per cycle
	function automatic logic [31:0] mix32_a(input logic [31:0] k);
		logic [31:0] a;
		a = (k + 32'h7ed55d16) + (k << 12);
		a = (a ^ 32'hc761c23c) ^ (a >> 19);
		return a;
	endfunction

	function automatic logic [31:0] mix32_b(input logic [31:0] k);
		logic [31:0] a;
		a = (k + 32'h165667b1) + (k << 5);
		a = (a + 32'hd3a2646c) ^ (a << 9);
		return a;
	endfunction

	function automatic logic [31:0] mix32_c(input logic [31:0] k);
		logic [31:0] a;
		a = (k + 32'hfd7046c5) + (k << 3);
		a = (a ^ 32'hb55a4f09) ^ (a >> 16);
		return a;
	endfunction

endpackage

>>> rtl/core/chained_hash_table_engine_unit.sv
// ----------------------------------------------------------------------------
// chained_hash_table_engine_unit
// Key-value table with chaining over a fixed node pool held in block memories.
// ----------------------------------------------------------------------------
// One item at a time, taken only while the engine is idle. The key hash runs
// in S_HASH, S_HASH2 and S_HASH3, the bucket head read in S_HEAD and S_NODE,
// and the chain walk passes each node through S_CHECK up to the matching node
// or chain end; the result is registered in S_DONE, and the engine then goes
// back to idle for the next item. An insert of a new key that reuses a freed
// node adds S_ALLOC and S_ALLOC2 for the free-list read, and a successful
// remove adds S_FREE to push the node onto the free list. A result held by
// the receiver does not stop the next item being taken; that item waits at
// its own result until the register frees. After reset a clearing pass
// writes the 1024 bucket heads, during which no item is accepted.
module chained_hash_table_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] key,
	input  logic [31:0] value_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        found,
	output logic [31:0] value_out
);
	import chte_pkg::*;

	logic [3:0]  lg_q;
	logic [3:0]  lg_eff;
	bkt_t        mask;
	state_t      state_q, state_d;

	logic [1:0]  act_q;
	logic [31:0] key_q, val_q, hash_q;
	bkt_t        bkt_q, clr_q;
	link_t       n_q, prev_q, head_q, nlink_q, free_q, fresh_q;
	cnt_t        steps_q, used_q;

	link_t       hd_mem   [BUCKETS];
	logic [31:0] key_mem  [NODE_POOL];
	logic [31:0] val_mem  [NODE_POOL];
	link_t       link_mem [NODE_POOL];

	link_t       hd_rd_q, link_rd_q;
	logic [31:0] key_rd_q, val_rd_q;

	logic        hd_we, key_we, val_we, lk_we;
	bkt_t        hd_wa;
	link_t       hd_wd, lk_wd;
	node_t       kv_wa, lk_wa, nd_ra;

	logic        live_n, live_f, hit, walk_end, go;
	logic        res_ld, res_f;
	status_t     res_st;
	logic [31:0] res_v;

	always_comb begin
		lg_eff = lg_q;
		if (lg_q < 4'(MIN_BUCKETS_LOG2)) lg_eff = 4'(MIN_BUCKETS_LOG2);
		if (lg_q > 4'(MAX_BUCKETS_LOG2)) lg_eff = 4'(MAX_BUCKETS_LOG2);
		mask = bkt_t'((11'd1 << lg_eff) - 11'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lg_q <= 4'(MIN_BUCKETS_LOG2);
		else if (cfg_we) lg_q <= cfg_wdata;
	end

	always_ff @(posedge clk) begin
		if (hd_we) hd_mem[hd_wa] <= hd_wd;
		hd_rd_q <= hd_mem[bkt_q];
	end

	always_ff @(posedge clk) begin
		if (key_we) key_mem[kv_wa] <= key_q;
		if (val_we) val_mem[kv_wa] <= val_q;
		if (lk_we) link_mem[lk_wa] <= lk_wd;
		key_rd_q  <= key_mem[nd_ra];
		val_rd_q  <= val_mem[nd_ra];
		link_rd_q <= link_mem[nd_ra];
	end

	assign live_n   = !n_q[NODE_W];
	assign live_f   = !free_q[NODE_W];
	assign hit      = live_n && (key_rd_q == key_q);
	assign walk_end = !live_n || hit || (steps_q == cnt_t'(NODE_POOL));
	assign go       = !out_valid || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (clr_q == bkt_t'(BUCKETS - 1)) state_d = S_IDLE;
			S_IDLE:  if (in_valid) state_d = S_HASH;
			S_HASH:  state_d = S_HASH2;
			S_HASH2: state_d = S_HASH3;
			S_HASH3: state_d = S_HEAD;
			S_HEAD:  state_d = S_NODE;
			S_NODE:  state_d = S_CHECK;
			S_CHECK: begin
				if (walk_end) begin
					if (act_q == ACT_INSERT && !hit && live_f) state_d = S_ALLOC;
					else state_d = S_DONE;
				end
			end
			S_ALLOC:  state_d = S_ALLOC2;
			S_ALLOC2: state_d = S_DONE;
			S_DONE: begin
				if (go) begin
					if (act_q == ACT_REMOVE && live_n) state_d = S_FREE;
					else state_d = S_IDLE;
				end
			end
			S_FREE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		hd_we = 1'b0; hd_wa = bkt_q; hd_wd = NULL_LINK;
		key_we = 1'b0; val_we = 1'b0; lk_we = 1'b0;
		kv_wa = n_q[NODE_W-1:0]; lk_wa = n_q[NODE_W-1:0]; lk_wd = free_q;
		nd_ra = n_q[NODE_W-1:0];
		res_ld = 1'b0; res_st = ST_NOTFOUND; res_f = 1'b0; res_v = '0;
		case (state_q)
			S_CLEAR: begin
				hd_we = 1'b1; hd_wa = clr_q;
			end
			S_NODE:  nd_ra = hd_rd_q[NODE_W-1:0];
			S_CHECK: nd_ra = link_rd_q[NODE_W-1:0];
			S_ALLOC: nd_ra = free_q[NODE_W-1:0];
			S_DONE: begin
				res_ld = go;
				case (act_q)
					ACT_INSERT: begin
						if (live_n) begin
							val_we = go; res_st = ST_OK;
						end else if (fresh_q[NODE_W]) begin
							res_st = ST_FULL;
						end else begin
							res_st = ST_OK;
							kv_wa = fresh_q[NODE_W-1:0]; lk_wa = fresh_q[NODE_W-1:0];
							key_we = go; val_we = go; lk_we = go; lk_wd = head_q;
							hd_we = go; hd_wd = fresh_q;
						end
					end
					ACT_REMOVE: begin
						if (live_n) begin
							res_st = ST_OK; res_f = 1'b1;
							if (!prev_q[NODE_W]) begin
								lk_we = go; lk_wa = prev_q[NODE_W-1:0]; lk_wd = nlink_q;
							end else begin
								hd_we = go; hd_wd = nlink_q;
							end
						end
					end
					ACT_LOOKUP: begin
						if (live_n) begin
							res_st = ST_OK; res_f = 1'b1; res_v = val_q;
						end
					end
					default: ;
				endcase
			end
			// removed node onto the free list
			S_FREE: lk_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			free_q <= NULL_LINK;
			used_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (res_ld) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			if (state_q == S_CHECK && walk_end && act_q == ACT_INSERT && !hit && !live_f
				&& !used_q[NODE_W]) used_q <= used_q + 1'b1;
			if (state_q == S_ALLOC2) free_q <= link_rd_q;
			if (state_q == S_FREE) free_q <= n_q;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					act_q <= action; key_q <= key; val_q <= value_in;
				end
			end
			S_HASH:  hash_q <= mix32_a(key_q);
			S_HASH2: hash_q <= mix32_b(hash_q);
			S_HASH3: begin
				bkt_q <= bkt_t'(mix32_c(hash_q)) & mask;
				prev_q <= NULL_LINK;
				steps_q <= '0;
			end
			S_NODE: begin
				n_q <= hd_rd_q;
				head_q <= hd_rd_q;
			end
			S_CHECK: begin
				if (walk_end) begin
					if (!hit) n_q <= NULL_LINK;
					nlink_q <= link_rd_q;
					if (act_q == ACT_LOOKUP) val_q <= val_rd_q;
					fresh_q <= used_q;
				end else begin
					prev_q <= n_q;
					n_q <= link_rd_q;
					steps_q <= steps_q + 1'b1;
				end
			end
			S_ALLOC: fresh_q <= free_q;
			default: ;
		endcase
		if (res_ld) begin
			status <= res_st; found <= res_f; value_out <= res_v;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value_out) && $stable(status))
		else $error("result dropped or changed while held");
	assert property (@(posedge clk) disable iff (!arst_n)
		!used_q[NODE_W] || used_q == cnt_t'(NODE_POOL))
		else $error("pool count overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		res_ld |-> go)
		else $error("result overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> in_stall)
		else $error("item taken while clearing");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHECK |-> steps_q <= cnt_t'(NODE_POOL))
		else $error("chain walk overrun");
endmodule

>>> bench/chained_hash_table_engine_unit_test.sv
// ----------------------------------------------------------------------------
// chained_hash_table_engine_unit_test
// Drives insert, remove and lookup items into the hash table engine, keeps a
// shadow table of its own, and checks every result item against it. Runs
// through several bucket counts, pool exhaustion and a long output hold-off.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_unit_test;
	import chte_pkg::*;

	typedef struct packed {
		action_t     act;
		logic [31:0] key;
		logic [31:0] val;
	} op_t;

	typedef struct packed {
		status_t     st;
		logic        fnd;
		logic [31:0] vout;
	} res_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [3:0]  cfg_wdata;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  action = 2'd0;
	logic [31:0] key = 32'd0;
	logic [31:0] value_in = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic        found;
	logic [31:0] value_out;

	chained_hash_table_engine_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .action(action), .key(key),
		.value_in(value_in), .out_valid(out_valid), .out_stall(out_stall),
		.status(status), .found(found), .value_out(value_out)
	);

	// shadow table
	logic [3:0]  lg_reg = 4'd4;
	link_t       heads [BUCKETS];
	logic [31:0] nkey  [NODE_POOL];
	logic [31:0] nval  [NODE_POOL];
	link_t       nlink [NODE_POOL];
	link_t       free_head;
	int unsigned fresh_cnt;

	op_t  pending [$];
	res_t awaited [$];
	logic [31:0] keys_used [$];
	int   errors = 0;
	int   results_seen = 0;
	int   accepted = 0;
	int   sent = 0;
	int   hold_len = 0;
	int   hold_cnt = 0;
	int   in_gap = 0;
	int   out_gap = 0;
	int   out_count = 0;
	int   out_draw;

	function automatic logic [31:0] key_hash(logic [31:0] k);
		logic [31:0] a;
		a = k;
		a = (a + 32'h7ed55d16) + (a << 12);
		a = (a ^ 32'hc761c23c) ^ (a >> 19);
		a = (a + 32'h165667b1) + (a << 5);
		a = (a + 32'hd3a2646c) ^ (a << 9);
		a = (a + 32'hfd7046c5) + (a << 3);
		a = (a ^ 32'hb55a4f09) ^ (a >> 16);
		return a;
	endfunction

	function automatic res_t table_apply(op_t o);
		int    lg;
		int    b;
		link_t n;
		link_t prv;
		link_t f;
		int    steps;
		res_t  r;
		lg = lg_reg;
		if (lg < MIN_BUCKETS_LOG2) lg = MIN_BUCKETS_LOG2;
		if (lg > MAX_BUCKETS_LOG2) lg = MAX_BUCKETS_LOG2;
		b = key_hash(o.key) & ((1 << lg) - 1);
		n = heads[b];
		prv = NULL_LINK;
		steps = 0;
		r = '{ST_NOTFOUND, 1'b0, 32'd0};
		while (n < NODE_POOL && steps < NODE_POOL && nkey[n[NODE_W-1:0]] != o.key) begin
			prv = n;
			n = nlink[n[NODE_W-1:0]];
			steps++;
		end
		if (!(n < NODE_POOL && nkey[n[NODE_W-1:0]] == o.key)) n = NULL_LINK;
		case (o.act)
			ACT_INSERT: begin
				if (n < NODE_POOL) begin
					nval[n[NODE_W-1:0]] = o.val;
					r.st = ST_OK;
				end else begin
					f = NULL_LINK;
					if (free_head < NODE_POOL) begin
						f = free_head;
						free_head = nlink[f[NODE_W-1:0]];
					end else if (fresh_cnt < NODE_POOL) begin
						f = link_t'(fresh_cnt);
						fresh_cnt++;
					end
					if (f < NODE_POOL) begin
						nkey[f[NODE_W-1:0]] = o.key;
						nval[f[NODE_W-1:0]] = o.val;
						nlink[f[NODE_W-1:0]] = heads[b];
						heads[b] = f;
						r.st = ST_OK;
					end else r.st = ST_FULL;
				end
			end
			ACT_REMOVE: begin
				if (n < NODE_POOL) begin
					if (prv < NODE_POOL) nlink[prv[NODE_W-1:0]] = nlink[n[NODE_W-1:0]];
					else heads[b] = nlink[n[NODE_W-1:0]];
					nlink[n[NODE_W-1:0]] = free_head;
					free_head = n;
					r.st = ST_OK;
					r.fnd = 1'b1;
				end
			end
			ACT_LOOKUP: begin
				if (n < NODE_POOL) begin
					r.st = ST_OK;
					r.fnd = 1'b1;
					r.vout = nval[n[NODE_W-1:0]];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
		errors++;
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#100000000;
		$display("chained_hash_table_engine_unit_test: done, errors");
		$finish;
	end

	// driver
	always @(negedge clk) begin
		if (in_valid) begin
			if (accepted == sent) begin
				in_valid <= 1'b0;
				in_gap <= $urandom_range(0, 8);
			end
		end else if (pending.size() > 0 && arst_n) begin
			if (in_gap > 0) in_gap <= in_gap - 1;
			else begin
				in_valid <= 1'b1;
				action   <= pending[0].act;
				key      <= pending[0].key;
				value_in <= pending[0].val;
				pending.pop_front();
				sent <= sent + 1;
			end
		end
	end

	// monitor and shadow update
	always @(posedge clk) begin
		if (!arst_n) begin
			free_head = NULL_LINK;
			fresh_cnt = 0;
			for (int i = 0; i < BUCKETS; i++) heads[i] = NULL_LINK;
			for (int i = 0; i < NODE_POOL; i++) begin
				nkey[i] = '0; nval[i] = '0; nlink[i] = NULL_LINK;
			end
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (awaited.size() == 0) begin
					report_mismatch("result item with nothing awaited", 32'd0, 32'd0);
				end else begin
					if (status != awaited[0].st)
						report_mismatch("status", 32'(status), 32'(awaited[0].st));
					if (found != awaited[0].fnd)
						report_mismatch("found", 32'(found), 32'(awaited[0].fnd));
					if (value_out != awaited[0].vout)
						report_mismatch("value_out", value_out, awaited[0].vout);
					awaited.pop_front();
				end
			end
			if (in_valid && !in_stall) begin
				awaited.push_back(table_apply('{action_t'(action), key, value_in}));
				accepted++;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cnt < hold_len) hold_cnt <= hold_cnt + 1;
	end

	always @(negedge clk) begin
		if (hold_cnt < hold_len) out_stall <= 1'b1;
		else if (results_seen != out_count) begin
			out_count <= results_seen;
			out_draw = $urandom_range(0, 8);
			out_stall <= (out_draw != 0);
			out_gap <= (out_draw > 0) ? out_draw - 1 : 0;
		end else if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			out_stall <= 1'b1;
		end else out_stall <= 1'b0;
	end

	function automatic logic [31:0] pick_key();
		if (keys_used.size() > 0 && $urandom_range(0, 3) != 0)
			return keys_used[$urandom_range(0, keys_used.size() - 1)];
		pick_key = $urandom();
		keys_used.push_back(pick_key);
	endfunction

	task automatic queue_op(action_t a, logic [31:0] k, logic [31:0] v);
		pending.push_back('{a, k, v});
	endtask

	task automatic drain();
		while (pending.size() > 0 || in_valid || awaited.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_buckets(logic [3:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		lg_reg = v;
	endtask

	task automatic random_phase(int count, logic [31:0] keyspan);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45) queue_op(ACT_INSERT, pick_key() % keyspan, $urandom());
			else if (r < 65) queue_op(ACT_REMOVE, pick_key() % keyspan, $urandom());
			else if (r < 97) queue_op(ACT_LOOKUP, pick_key() % keyspan, $urandom());
			else queue_op(ACT_NONE, pick_key(), $urandom());
		end
	endtask

	initial begin
		arst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = 4'd0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed
		queue_op(ACT_LOOKUP, 32'd0, 32'd0);
		queue_op(ACT_REMOVE, 32'hffffffff, 32'd0);
		queue_op(ACT_INSERT, 32'd0, 32'hffffffff);
		queue_op(ACT_INSERT, 32'hffffffff, 32'h0);
		queue_op(ACT_LOOKUP, 32'd0, 32'd0);
		queue_op(ACT_LOOKUP, 32'hffffffff, 32'hffffffff);
		queue_op(ACT_INSERT, 32'd0, 32'h5a5aa5a5);
		queue_op(ACT_LOOKUP, 32'd0, 32'd0);
		queue_op(ACT_NONE, 32'd0, 32'hffffffff);
		for (int i = 1; i <= 6; i++) queue_op(ACT_INSERT, i, ~i);
		queue_op(ACT_REMOVE, 32'd3, 32'd0);
		queue_op(ACT_REMOVE, 32'd3, 32'd0);
		queue_op(ACT_LOOKUP, 32'd3, 32'd0);
		queue_op(ACT_INSERT, 32'd77, 32'd77);
		queue_op(ACT_LOOKUP, 32'd6, 32'd0);
		queue_op(ACT_REMOVE, 32'd0, 32'd0);
		drain();

		// register extremes, including out-of-range values
		set_buckets(4'd15);
		queue_op(ACT_LOOKUP, 32'd1, 32'd0);
		queue_op(ACT_LOOKUP, 32'hffffffff, 32'd0);
		random_phase(20, 64);
		drain();
		set_buckets(4'd0);
		random_phase(20, 64);
		drain();

		// long receiver hold-off while the sender keeps offering
		hold_len = 300;
		set_buckets(4'd10);
		random_phase(30, 32'hffffffff);
		drain();
		set_buckets(4'd7);
		random_phase(10, 256);
		drain();

		// exhaust the pool with a small bucket count
		set_buckets(4'd4);
		for (int i = 0; i < NODE_POOL + 8; i++) queue_op(ACT_INSERT, $urandom(), $urandom());
		drain();
		random_phase(15, 32'hffffffff);
		drain();
		set_buckets(4'd5);
		random_phase(10, 32'hffffffff);
		drain();

		$display("covered %0d items over bucket counts 16 to 1024, pool exhaustion", accepted);
		$display("and a long output hold-off; %0d result items checked", results_seen);
		if (errors == 0 && awaited.size() == 0) begin
			$display("chained_hash_table_engine_unit_test: done, clean");
		end else begin
			$display("chained_hash_table_engine_unit_test: done, errors");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/chte_pkg.sv
rtl/core/chained_hash_table_engine_unit.sv
bench/chained_hash_table_engine_unit_test.sv
